// ===== design/bnfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bnfp_pkg
// Shared types and constants for the binary navigation frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bnfp_pkg;

    localparam int BUFFER_BYTES_DEF = 256;

    localparam logic [7:0] SYNC_FIRST   = 8'hB5;
    localparam logic [7:0] SYNC_SECOND  = 8'h62;
    localparam int         HEADER_BYTES = 6;
    localparam int         CHECK_BYTES  = 2;

    // command codes
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_t;

    typedef struct packed {
        logic       frame_done;
        logic       frame_good;
        logic [7:0] frame_class;
        logic [7:0] msg_ident;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } out_t;

endpackage

// ===== design/binary_nav_frame_parser.sv =====
// ----------------------------------------------------------------------------
// binary_nav_frame_parser
// Byte-serial parser for sync-prefixed binary navigation frames with a
// Fletcher-8 check and a frame buffer that software can read back.
//
// Input channel (s_): one transaction per byte. cmd CMD_RX feeds a receiver
// byte into the parser; cmd CMD_READ reads frame buffer entry read_index
// (wrapped to the buffer depth). Every input transaction gives exactly one
// result transaction on the m_ channel, in order.
// The result is registered and presented in the cycle after the input transaction.
// Throughput: one transaction per cycle, sustained while m_ready is high.
// The parser state update and the single buffer write port take every accepted byte.
// The longest frame held is BUFFER_BYTES - 1 bytes; longer frames are dropped.
// Reset (aresetn low, synchronous): parser waits for the first sync byte,
// the output stage is emptied. Buffer contents are not cleared.
// Receiver stall: the result stays on m_data until taken; s_ready drops only
// while a result is held and m_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_nav_frame_parser #(
    parameter int BUFFER_BYTES = bnfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bnfp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bnfp_pkg::out_t m_data
);
    import bnfp_pkg::*;

    // buffer address / byte position width
    localparam int AW = $clog2(BUFFER_BYTES);

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHECK_A = 4'd7,
        PH_CHECK_B = 4'd8
    } phase_t;

    // parser state
    phase_t      phase_reg,  phase_next;
    logic [AW-1:0] count_reg, count_next;
    logic [15:0] len_reg,    len_next;
    logic [7:0]  sum_a_reg,  sum_a_next;
    logic [7:0]  sum_b_reg,  sum_b_next;
    logic [7:0]  class_reg,  class_next;
    logic [7:0]  ident_reg,  ident_next;
    logic [7:0]  ck_a_reg,   ck_a_next;

    // output stage
    logic        out_valid_reg;
    out_t        out_reg, out_next;
    logic        out_is_read_reg;

    // frame buffer
    logic [7:0]    frame_mem [BUFFER_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic   accept;
    phase_t phase_eff;
    logic [AW-1:0] count_eff;
    logic [AW-1:0] count_inc;
    logic [7:0]  b;
    logic [7:0]  sum_a_add;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.rx_byte;

    // read index wraps to the buffer depth
    generate
        if (BUFFER_BYTES >= 256) begin : g_rd_wide
            assign rd_addr = AW'(s_data.read_index);
        end else begin : g_rd_wrap
            logic [AW-1:0] wrap_tbl [256];
            for (genvar i = 0; i < 256; i++) begin : g_tbl
                assign wrap_tbl[i] = AW'(i % BUFFER_BYTES);
            end
            assign rd_addr = wrap_tbl[s_data.read_index];
        end
    endgenerate

    // Parser next state. A byte that would land in the last buffer slot,
    // or an unused phase code, restarts the search at position 0.
    always_comb begin
        if (phase_reg > PH_CHECK_B || count_reg >= AW'(BUFFER_BYTES - 1)) begin
            phase_eff = PH_SYNC1;
            count_eff = '0;
        end else begin
            phase_eff = phase_reg;
            count_eff = count_reg;
        end
        count_inc  = count_eff + AW'(1);
        sum_a_add  = sum_a_reg + b;

        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        class_next = class_reg;
        ident_next = ident_reg;
        ck_a_next  = ck_a_reg;
        wr_addr    = count_eff;

        out_next              = '0;
        out_next.read_data    = 8'h00;

        unique case (phase_eff)
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    phase_next = PH_CLASS;
                    count_next = count_inc;
                end else begin
                    phase_next = PH_SYNC1;
                    count_next = '0;
                end
            end
            PH_CLASS: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                class_next = b;
                phase_next = PH_IDENT;
                count_next = count_inc;
            end
            PH_IDENT: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                ident_next = b;
                phase_next = PH_LEN_LO;
                count_next = count_inc;
            end
            PH_LEN_LO: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                len_next   = {8'h00, b};
                phase_next = PH_LEN_HI;
                count_next = count_inc;
            end
            PH_LEN_HI: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                len_next   = {b, len_reg[7:0]};
                // empty payload goes straight to the check bytes
                phase_next = ({b, len_reg[7:0]} == 16'h0000) ? PH_CHECK_A : PH_PAYLOAD;
                count_next = count_inc;
            end
            PH_PAYLOAD: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                count_next = count_inc;
                if (17'(count_inc) == 17'(len_reg) + 17'(HEADER_BYTES)) begin
                    phase_next = PH_CHECK_A;
                end
            end
            PH_CHECK_A: begin
                ck_a_next  = b;
                phase_next = PH_CHECK_B;
                count_next = count_inc;
            end
            PH_CHECK_B: begin
                out_next.frame_done   = 1'b1;
                out_next.frame_good   = (ck_a_reg == sum_a_reg) && (b == sum_b_reg);
                out_next.frame_class  = class_reg;
                out_next.msg_ident    = ident_reg;
                out_next.frame_length = len_reg[7:0] + 8'(HEADER_BYTES + CHECK_BYTES);
                phase_next = PH_SYNC1;
                count_next = '0;
            end
            default: begin
                wr_addr = '0;
                if (b == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                    count_next = AW'(1);
                end else begin
                    phase_next = PH_SYNC1;
                    count_next = '0;
                end
            end
        endcase
    end

    // Parser state and output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC1;
            count_reg     <= '0;
            len_reg       <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && s_data.cmd == CMD_RX) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
        end
        if (accept) begin
            out_is_read_reg <= (s_data.cmd == CMD_READ);
            if (s_data.cmd == CMD_RX) begin
                out_reg   <= out_next;
                class_reg <= class_next;
                ident_reg <= ident_next;
                ck_a_reg  <= ck_a_next;
            end else begin
                out_reg <= '0;
            end
        end
    end

    // Frame buffer: one write port, one registered read port.
    // A read transaction never shares a cycle with a write, so it sees every earlier write.
    always_ff @(posedge aclk) begin
        if (accept && s_data.cmd == CMD_RX) begin
            frame_mem[wr_addr] <= b;
        end
        if (accept && s_data.cmd == CMD_READ) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_comb begin
        m_data           = out_reg;
        m_data.read_data = out_is_read_reg ? rd_data_reg : 8'h00;
    end
    assign m_valid = out_valid_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_good_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_good |-> m_data.frame_done)
        else $error("frame_good without frame_done");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= AW'(BUFFER_BYTES - 1))
        else $error("byte position beyond buffer");

    a_sync1_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SYNC1 |-> count_reg == '0)
        else $error("sync search not at position zero");

    a_check_b_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.cmd == CMD_RX && phase_eff == PH_CHECK_B
        |=> m_valid && m_data.frame_done)
        else $error("second check byte did not complete a frame");

    a_read_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.cmd == CMD_READ |=> m_valid && !m_data.frame_done)
        else $error("read transaction reported a frame");

endmodule

// ===== test/tb_binary_nav_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_binary_nav_frame_parser
// Self-checking bench for the frame parser. A short table of directed
// transactions comes first: bad syncs, a zero-length frame, a bad-check
// frame, and buffer reads. Random traffic follows. It is mostly well-formed
// frames with random content, mixed with noise, cut-off frames, overflows
// and buffer reads. A built-in parser model predicts every result that the
// table does not give by hand, and the results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_nav_frame_parser;

    import bnfp_pkg::*;

    localparam int BUF_DEPTH      = BUFFER_BYTES_DEF;
    localparam int BUF_AW         = $clog2(BUF_DEPTH);
    // longest payload whose frame still fits: BUF_DEPTH - 1 bytes in all
    localparam int MAX_PAYLOAD    = BUF_DEPTH - 1 - HEADER_BYTES - CHECK_BYTES;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [3:0] {
        P_SYNC1, P_SYNC2, P_CLASS, P_IDENT, P_LEN_LO, P_LEN_HI,
        P_PAYLOAD, P_CHECK_A, P_CHECK_B
    } parse_phase_e;

    typedef enum logic [1:0] {RCV_OPEN, RCV_COIN, RCV_SPARSE, RCV_PERIODIC} rcv_mode_e;

    typedef enum int {CK_CLEAN, CK_BAD_A, CK_BAD_B} ck_fault_e;

    // one row of the directed table; 'known' rows carry a hand-typed result
    typedef struct {
        in_t  item;
        bit   known;
        out_t want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    binary_nav_frame_parser DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model state (advanced once per accepted receiver byte)
    // ------------------------------------------------------------------------
    parse_phase_e prs_phase = P_SYNC1;
    int unsigned  prs_pos   = 0;
    logic [15:0]  prs_len   = '0;
    logic [7:0]   prs_sum_a = '0;
    logic [7:0]   prs_sum_b = '0;
    logic [7:0]   prs_mem     [BUF_DEPTH];
    bit           prs_mem_set [BUF_DEPTH];   // entries safe to read back

    out_t      frame_result_q[$];   // results still owed by the DUT
    dir_row_t  dir_rows[$];
    int        burst_left = 0;
    int        items_sent = 0;
    int        n_reads    = 0;
    int        n_good     = 0;
    int        n_bad      = 0;
    int        fail_count = 0;
    int        idle_cycles = 0;
    rcv_mode_e rcv_mode   = RCV_OPEN;
    int        rcv_left   = 0;
    out_t      mon_want;

    function automatic void mem_put(logic [7:0] b);
        prs_mem[BUF_AW'(prs_pos % BUF_DEPTH)]     = b;
        prs_mem_set[BUF_AW'(prs_pos % BUF_DEPTH)] = 1'b1;
        prs_pos++;
    endfunction

    function automatic void sum_add(logic [7:0] b);
        prs_sum_a = prs_sum_a + b;
        prs_sum_b = prs_sum_b + prs_sum_a;
    endfunction

    // Next result of the parser for one input transaction.
    function automatic out_t predict_parse(in_t it);
        out_t       r;
        logic [7:0] b;
        logic [7:0] ck_a_seen;
        int         total;
        r = '0;
        b = it.rx_byte;
        if (it.cmd == CMD_READ) begin
            r.read_data = prs_mem[BUF_AW'(it.read_index % BUF_DEPTH)];
            return r;
        end
        // a byte that would land in the last slot drops the partial frame
        if (prs_pos + 1 >= BUF_DEPTH) begin
            prs_phase = P_SYNC1;
            prs_pos   = 0;
        end
        case (prs_phase)
            P_SYNC2: begin
                mem_put(b);
                if (b == SYNC_SECOND) begin
                    prs_sum_a = '0;
                    prs_sum_b = '0;
                    prs_phase = P_CLASS;
                end else begin
                    // restart; this byte is not retried as a first sync
                    prs_phase = P_SYNC1;
                    prs_pos   = 0;
                end
            end
            P_CLASS: begin
                mem_put(b); sum_add(b);
                prs_phase = P_IDENT;
            end
            P_IDENT: begin
                mem_put(b); sum_add(b);
                prs_phase = P_LEN_LO;
            end
            P_LEN_LO: begin
                mem_put(b); sum_add(b);
                prs_len   = {8'h00, b};
                prs_phase = P_LEN_HI;
            end
            P_LEN_HI: begin
                mem_put(b); sum_add(b);
                prs_len[15:8] = b;
                prs_phase = (prs_len == 16'd0) ? P_CHECK_A : P_PAYLOAD;
            end
            P_PAYLOAD: begin
                mem_put(b); sum_add(b);
                if (prs_pos == prs_len + HEADER_BYTES) prs_phase = P_CHECK_A;
            end
            P_CHECK_A: begin
                mem_put(b);
                prs_phase = P_CHECK_B;
            end
            P_CHECK_B: begin
                ck_a_seen = prs_mem[BUF_AW'((prs_pos - 1) % BUF_DEPTH)];
                mem_put(b);
                total = prs_len + HEADER_BYTES + CHECK_BYTES;
                r.frame_done   = 1'b1;
                r.frame_good   = (ck_a_seen == prs_sum_a) && (b == prs_sum_b);
                r.frame_class  = prs_mem[2];
                r.msg_ident    = prs_mem[3];
                r.frame_length = total[7:0];
                prs_phase = P_SYNC1;
                prs_pos   = 0;
            end
            default: begin
                // hunting for the first sync; every byte lands at slot 0
                prs_pos = 0;
                mem_put(b);
                if (b == SYNC_FIRST) begin
                    prs_phase = P_SYNC2;
                end else begin
                    prs_phase = P_SYNC1;
                    prs_pos   = 0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(logic cmd, logic [7:0] b, logic [7:0] idx,
                                    bit known, out_t want);
        dir_row_t row;
        row.item.cmd        = cmd;
        row.item.rx_byte    = b;
        row.item.read_index = idx;
        row.known = known;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by idle gaps.
    // Called at a rising edge; returns at the edge the transaction is taken.
    // ------------------------------------------------------------------------
    task automatic push_item(in_t it, bit known, out_t want);
        out_t pred;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = predict_parse(it);
        frame_result_q.insert(frame_result_q.size(), known ? want : pred);
        items_sent++;
        if (it.cmd == CMD_READ) n_reads++;
        if (pred.frame_done) begin
            if (pred.frame_good) n_good++;
            else n_bad++;
        end
    endtask

    task automatic send_rx(logic [7:0] b);
        in_t it;
        it.cmd        = CMD_RX;
        it.rx_byte    = b;
        it.read_index = 8'($urandom_range(0, 255));   // ignored for receiver bytes
        push_item(it, 1'b0, '0);
    endtask

    // read back a slot that has been written at least once
    task automatic send_read();
        in_t         it;
        int unsigned idx;
        do idx = $urandom_range(0, BUF_DEPTH - 1); while (!prs_mem_set[BUF_AW'(idx)]);
        it.cmd        = CMD_READ;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.read_index = 8'(idx);
        push_item(it, 1'b0, '0);
    endtask

    // Build a frame with random class, id and payload. 'cut' >= 0 stops after
    // that many bytes. Oversized lengths have their payload capped at MAX_PAYLOAD + 4.
    task automatic send_frame(int unsigned plen, ck_fault_e fault, int cut);
        logic [7:0]  fb[$];
        logic [15:0] len16;
        logic [7:0]  sa;
        logic [7:0]  sb;
        int          n;
        int          body;
        len16 = plen[15:0];
        sa = '0;
        sb = '0;
        fb.insert(fb.size(), SYNC_FIRST);
        fb.insert(fb.size(), SYNC_SECOND);
        fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        fb.insert(fb.size(), len16[7:0]);
        fb.insert(fb.size(), len16[15:8]);
        body = (plen > MAX_PAYLOAD + 4) ? MAX_PAYLOAD + 4 : plen;
        for (int k = 0; k < body; k++) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        for (int k = 2; k < fb.size(); k++) begin
            sa = sa + fb[k];
            sb = sb + sa;
        end
        fb.insert(fb.size(), fault == CK_BAD_A ? sa ^ 8'($urandom_range(1, 255)) : sa);
        fb.insert(fb.size(), fault == CK_BAD_B ? sb ^ 8'($urandom_range(1, 255)) : sb);
        n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 24) == 0) send_read();   // read mid-frame
            send_rx(fb[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern switches at random between open, coin-flip, sparse and periodic modes
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rcv_left == 0) begin
            rcv_mode = rcv_mode_e'($urandom_range(0, 3));
            rcv_left = $urandom_range(20, 200);
        end else begin
            rcv_left--;
        end
        case (rcv_mode)
            RCV_OPEN:   m_ready <= 1'b1;
            RCV_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RCV_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:    m_ready <= (rcv_left % 3 == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_result_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] result with nothing pending: %p", $time, m_data);
            end else begin
                mon_want = frame_result_q.pop_front();
                if (m_data !== mon_want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"[%0t] mismatch exp done=%0b good=%0b cls=%02h id=%02h ",
                                  "len=%02h rd=%02h | got done=%0b good=%0b cls=%02h ",
                                  "id=%02h len=%02h rd=%02h"}, $time,
                                 mon_want.frame_done, mon_want.frame_good,
                                 mon_want.frame_class, mon_want.msg_ident,
                                 mon_want.frame_length, mon_want.read_data,
                                 m_data.frame_done, m_data.frame_good,
                                 m_data.frame_class, m_data.msg_ident,
                                 m_data.frame_length, m_data.read_data);
                end
            end
        end
    end

    // watchdog: any transaction on either channel clears it
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned plen;
        int unsigned pick;
        ck_fault_e   fault;

        // Directed table. Hand-typed results where they are obvious; the rest
        // come from the model.
        add_row(CMD_RX,   8'h00, 8'h00, 1, '0);            // bad first sync after reset
        add_row(CMD_READ, 8'h00, 8'h00, 1, '0);            // slot 0 now holds 0x00
        add_row(CMD_RX,   SYNC_FIRST,  8'h00, 1, '0);
        add_row(CMD_RX,   SYNC_SECOND, 8'h00, 1, '0);
        add_row(CMD_RX,   8'hFF, 8'h00, 1, '0);            // class
        add_row(CMD_RX,   8'h00, 8'hFF, 1, '0);            // id
        add_row(CMD_RX,   8'h00, 8'h00, 1, '0);            // length 0: straight to check
        add_row(CMD_RX,   8'h00, 8'h00, 1, '0);
        add_row(CMD_READ, 8'hFF, 8'h02, 1, {26'd0, 8'hFF}); // read does not disturb parse
        add_row(CMD_RX,   8'hFF, 8'h00, 1, '0);            // ck_a
        add_row(CMD_RX,   8'hFC, 8'h00, 1, {1'b1, 1'b1, 8'hFF, 8'h00, 8'd8, 8'h00});
        add_row(CMD_READ, 8'h00, 8'h07, 1, {26'd0, 8'hFC});
        add_row(CMD_RX,   SYNC_FIRST,  8'h00, 0, '0);      // bad second sync ...
        add_row(CMD_RX,   SYNC_FIRST,  8'h00, 0, '0);
        add_row(CMD_RX,   SYNC_SECOND, 8'h00, 0, '0);      // ... not retried as first
        add_row(CMD_RX,   SYNC_FIRST,  8'h00, 0, '0);      // one-byte frame, bad check
        add_row(CMD_RX,   SYNC_SECOND, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h01, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h02, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h01, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h00, 8'h00, 0, '0);
        add_row(CMD_RX,   8'hAA, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h00, 8'h00, 0, '0);
        add_row(CMD_RX,   8'h00, 8'h00, 1, {1'b1, 1'b0, 8'h01, 8'h02, 8'd9, 8'h00});
        add_row(CMD_READ, 8'h00, 8'h06, 1, {26'd0, 8'hAA});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);

        // longest frame that fits, then one a byte too long
        send_frame(MAX_PAYLOAD, CK_CLEAN, -1);
        send_frame(MAX_PAYLOAD + 1, CK_CLEAN, -1);

        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            plen = $urandom_range(0, 99);
            plen = (plen < 70) ? $urandom_range(0, 12) :
                   (plen < 97) ? $urandom_range(13, 64) :
                                 $urandom_range(200, MAX_PAYLOAD);
            fault = ($urandom_range(0, 9) < 8) ? CK_CLEAN
                                               : ck_fault_e'($urandom_range(1, 2));
            if (pick < 60) begin
                send_frame(plen, fault, -1);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 4)) send_read();
            end else if (pick < 80) begin
                // line noise, with stray first-sync bytes in it
                repeat ($urandom_range(1, 6))
                    send_rx(($urandom_range(0, 3) == 0) ? SYNC_FIRST
                                                        : 8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                // frame cut short; the next bytes get swallowed as its tail
                send_frame(plen, CK_CLEAN, $urandom_range(1, plen + 7));
            end else if (pick < 96) begin
                send_rx(SYNC_FIRST);
                send_rx(SYNC_SECOND ^ 8'($urandom_range(1, 255)));
            end else if (pick < 99) begin
                send_frame(0, fault, -1);
            end else begin
                // oversized: length over the store, or a nonzero high byte
                send_frame(($urandom_range(0, 1) == 1) ? $urandom_range(256, 65535)
                                                       : $urandom_range(MAX_PAYLOAD + 1, 255),
                           CK_CLEAN, -1);
            end
        end

        s_valid <= 1'b0;
        wait (frame_result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (frame_result_q.size() != 0) fail_count++;

        $display("Ran %0d transactions: %0d receiver bytes, %0d buffer reads.",
                 items_sent, items_sent - n_reads, n_reads);
        $display("Frames completed: %0d with matching check, %0d with bad check; %0d failures.",
                 n_good, n_bad, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
